>>> rtl/kssp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kssp_pkg
// Shared types and constants of the keyed start/stop pair matcher.
// ----------------------------------------------------------------------------
package kssp_pkg;

    localparam int NUM_VOICES  = 16;
    localparam int NUM_PITCHES = 128;
    localparam int TABLE_DEPTH = NUM_VOICES * NUM_PITCHES;
    localparam int KEY_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // request type codes
    localparam logic REQ_NOTE  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_LINK   = 2'd0;
    localparam logic [1:0] KIND_DSTOP  = 2'd1;
    localparam logic [1:0] KIND_DSTART = 2'd2;

    typedef struct packed {
        logic [15:0] measure;
        logic [3:0]  voice_slot;
        logic [7:0]  evt;
        logic [3:0]  note;
    } note_ref_t;

    typedef struct packed {
        logic      valid;
        note_ref_t nref;
    } entry_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage
`default_nettype wire

>>> rtl/keyed_start_stop_pair_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_start_stop_pair_matcher_top
// Pairs tie starts with tie stops through a table of pending starts.
// ----------------------------------------------------------------------------
// After reset, busy stays high while the pending-start table is swept clear,
// one entry at a time; no request is taken in that time. From then on busy
// stays low and a request may be given with start in every cycle.
// Each request is one read-modify-write of a single table entry: the entry is
// read in the cycle after the transfer, updated and written back in the same
// cycle, and any result is registered in the result register and shows on
// the result ports, marked by result_valid, for exactly one cycle. A request at
// most gives one result and the results come in request order. The receiver
// cannot stall the block, so results must be taken in the cycle they appear.
// ----------------------------------------------------------------------------
module keyed_start_stop_pair_matcher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [3:0]  voice_number,
    input  wire logic [6:0]  pitch,
    input  wire logic        tie_start,
    input  wire logic        tie_stop,
    input  wire logic [15:0] measure_index,
    input  wire logic [3:0]  voice_slot,
    input  wire logic [7:0]  event_index,
    input  wire logic [3:0]  note_index,
    output logic             result_valid,
    output logic [1:0]       kind,
    output logic [15:0]      from_measure,
    output logic [3:0]       from_voice_slot,
    output logic [7:0]       from_event,
    output logic [3:0]       from_note,
    output logic [15:0]      to_measure,
    output logic [3:0]       to_voice_slot,
    output logic [7:0]       to_event,
    output logic [3:0]       to_note,
    output logic [3:0]       voice_tag
);

    localparam int KW = kssp_pkg::KEY_W;
    localparam logic [KW-1:0] LAST_KEY = KW'(kssp_pkg::TABLE_DEPTH - 1);

    // control
    kssp_pkg::state_t state_reg, state_next;
    logic [KW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clr_we;
    logic             accept;
    logic             in_range;
    logic [KW-1:0]    in_key;

    // table memory
    kssp_pkg::entry_t mem [kssp_pkg::TABLE_DEPTH];
    kssp_pkg::entry_t rd_data_reg;
    logic             wr_en;
    logic [KW-1:0]    wr_addr;
    kssp_pkg::entry_t wr_data;

    // request stage
    logic               s1_valid_reg;
    logic               s1_req_reg;
    logic               s1_start_reg;
    logic               s1_stop_reg;
    logic [3:0]         s1_voice_reg;
    logic [KW-1:0]      s1_key_reg;
    kssp_pkg::note_ref_t s1_self_reg;
    logic               fwd_hit_reg;
    kssp_pkg::entry_t   fwd_data_reg;

    // update logic
    kssp_pkg::entry_t    cur_entry;
    kssp_pkg::entry_t    new_entry;
    logic                res_valid;
    logic [1:0]          res_kind;
    kssp_pkg::note_ref_t res_from;
    kssp_pkg::note_ref_t res_to;

    // ------------------------------------------------------------------
    // Clearing sweep and run state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            kssp_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + KW'(1);
                if (clr_cnt_reg == LAST_KEY)
                begin
                    state_next = kssp_pkg::ST_RUN;
                end
            end
            kssp_pkg::ST_RUN:
            begin
                state_next = kssp_pkg::ST_RUN;
            end
            default:
            begin
                state_next = kssp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        clr_we = 1'b0;
        case (state_reg)
            kssp_pkg::ST_CLEAR:
            begin
                busy   = 1'b1;
                clr_we = 1'b1;
            end
            kssp_pkg::ST_RUN:
            begin
                busy   = 1'b0;
                clr_we = 1'b0;
            end
            default:
            begin
                busy   = 1'b1;
                clr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kssp_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Request transfer and table read
    // ------------------------------------------------------------------
    assign accept   = start && !busy;
    assign in_range = (int'(voice_number) < kssp_pkg::NUM_VOICES) &&
                      (int'(pitch) < kssp_pkg::NUM_PITCHES);
    assign in_key   = KW'({voice_number, pitch});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type;
            s1_start_reg <= tie_start;
            s1_stop_reg  <= tie_stop;
            s1_voice_reg <= voice_number;
            s1_key_reg   <= in_key;
            s1_self_reg  <= '{measure: measure_index, voice_slot: voice_slot,
                               evt: event_index, note: note_index};
            // the entry being written this cycle is not yet in the read data
            fwd_hit_reg  <= wr_en && (wr_addr == in_key);
            fwd_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[in_key];
    end

    // ------------------------------------------------------------------
    // Modify the entry and form the result
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        new_entry = cur_entry;
        res_valid = 1'b0;
        res_kind  = kssp_pkg::KIND_LINK;
        res_from  = '0;
        res_to    = '0;
        if (s1_req_reg == kssp_pkg::REQ_FLUSH)
        begin
            res_valid       = cur_entry.valid;
            res_kind        = kssp_pkg::KIND_DSTART;
            res_from        = cur_entry.nref;
            new_entry.valid = 1'b0;
        end
        else
        begin
            if (s1_stop_reg)
            begin
                res_valid = 1'b1;
                res_to    = s1_self_reg;
                if (cur_entry.valid)
                begin
                    res_kind = kssp_pkg::KIND_LINK;
                    res_from = cur_entry.nref;
                end
                else
                begin
                    res_kind = kssp_pkg::KIND_DSTOP;
                end
                new_entry.valid = 1'b0;
            end
            if (s1_start_reg)
            begin
                new_entry.valid = 1'b1;
                new_entry.nref  = s1_self_reg;
            end
        end
    end

    always_comb
    begin
        if (clr_we)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_valid_reg;
            wr_addr = s1_key_reg;
            wr_data = new_entry;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= s1_valid_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            kind            <= res_kind;
            from_measure    <= res_from.measure;
            from_voice_slot <= res_from.voice_slot;
            from_event      <= res_from.evt;
            from_note       <= res_from.note;
            to_measure      <= res_to.measure;
            to_voice_slot   <= res_to.voice_slot;
            to_event        <= res_to.evt;
            to_note         <= res_to.note;
            voice_tag       <= s1_voice_reg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/kssp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kssp_checker
// Port-level checks on the pair matcher, bound to the top level.
// ----------------------------------------------------------------------------
module kssp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        req_type,
    input wire logic [3:0]  voice_number,
    input wire logic        result_valid,
    input wire logic [1:0]  kind,
    input wire logic [15:0] to_measure,
    input wire logic [3:0]  to_voice_slot,
    input wire logic [7:0]  to_event,
    input wire logic [3:0]  to_note,
    input wire logic [3:0]  voice_tag
);

    // a result only follows an accepted transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without a matching transfer");

    // the result carries the key's voice of its own request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> voice_tag == $past(voice_number, 2))
        else $error("voice tag does not match its request");

    // a flush can only report a dangling start
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(req_type, 2) == kssp_pkg::REQ_FLUSH)
            |-> kind == kssp_pkg::KIND_DSTART)
        else $error("flush gave a result other than a dangling start");

    // a dangling start has no stop note
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == kssp_pkg::KIND_DSTART) |->
            (to_measure == 16'd0 && to_voice_slot == 4'd0 &&
             to_event == 8'd0 && to_note == 4'd0))
        else $error("dangling start with stop note fields set");

endmodule

bind keyed_start_stop_pair_matcher_top kssp_checker u_kssp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .voice_number (voice_number),
    .result_valid (result_valid),
    .kind         (kind),
    .to_measure   (to_measure),
    .to_voice_slot(to_voice_slot),
    .to_event     (to_event),
    .to_note      (to_note),
    .voice_tag    (voice_tag)
);
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the keyed start/stop pair matcher.
// ----------------------------------------------------------------------------
// A short directed sequence covers the extreme keys and field values, links,
// dangling stops, dangling starts, replaced starts, notes carrying both flags
// or neither, and flushes of empty keys. Random phases follow. Most items land
// on a small pool of keys so that starts find their stops. Each phase ends by
// flushing its pool in ascending key order. A tracker object keeps its own
// copy of the pending-start table, predicts the report of every accepted
// request, and compares each report the block gives against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  voice;
        logic [6:0]  pitch;
        logic        tie_start;
        logic        tie_stop;
        logic [15:0] measure;
        logic [3:0]  vslot;
        logic [7:0]  evt;
        logic [3:0]  note;
    } tie_request_t;

    typedef struct packed {
        logic [1:0]          kind;
        kssp_pkg::note_ref_t from_ref;
        kssp_pkg::note_ref_t to_ref;
        logic [3:0]          voice_tag;
    } tie_report_t;

    class tie_tracker;
        logic                open_valid [kssp_pkg::TABLE_DEPTH];
        kssp_pkg::note_ref_t open_ref   [kssp_pkg::TABLE_DEPTH];
        tie_report_t         expected_reports [$];
        int                  failures;

        function new();
            foreach (open_valid[i])
            begin
                open_valid[i] = 1'b0;
                open_ref[i]   = '0;
            end
            failures = 0;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        // Update the table for one accepted request and queue its report.
        function void note_request(tie_request_t r);
            int unsigned         slot;
            kssp_pkg::note_ref_t self;
            tie_report_t         rep;
            bit                  has_report;
            has_report = 1'b0;
            if (int'(r.voice) >= kssp_pkg::NUM_VOICES ||
                int'(r.pitch) >= kssp_pkg::NUM_PITCHES)
                return;
            slot = int'(r.voice) * kssp_pkg::NUM_PITCHES + int'(r.pitch);
            rep = '0;
            rep.voice_tag = r.voice;
            if (r.req_type == kssp_pkg::REQ_FLUSH)
            begin
                if (open_valid[slot])
                begin
                    rep.kind = kssp_pkg::KIND_DSTART;
                    rep.from_ref = open_ref[slot];
                    open_valid[slot] = 1'b0;
                    has_report = 1'b1;
                end
            end
            else
            begin
                self.measure    = r.measure;
                self.voice_slot = r.vslot;
                self.evt        = r.evt;
                self.note       = r.note;
                // the stop is resolved before the start is stored
                if (r.tie_stop)
                begin
                    if (open_valid[slot])
                    begin
                        rep.kind = kssp_pkg::KIND_LINK;
                        rep.from_ref = open_ref[slot];
                        open_valid[slot] = 1'b0;
                    end
                    else
                        rep.kind = kssp_pkg::KIND_DSTOP;
                    rep.to_ref = self;
                    has_report = 1'b1;
                end
                if (r.tie_start)
                begin
                    open_ref[slot]   = self;
                    open_valid[slot] = 1'b1;
                end
            end
            if (has_report)
                expected_reports.push_back(rep);
        endfunction

        function void check_report(tie_report_t got);
            tie_report_t want;
            string       diffs;
            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected report kind=%0d tag=%0d", $realtime,
                             got.kind, got.voice_tag);
                return;
            end
            want = expected_reports.pop_front();
            diffs = "";
            if (got.kind !== want.kind) diffs = {diffs, " kind"};
            if (got.from_ref.measure !== want.from_ref.measure) diffs = {diffs, " from_measure"};
            if (got.from_ref.voice_slot !== want.from_ref.voice_slot)
                diffs = {diffs, " from_voice_slot"};
            if (got.from_ref.evt !== want.from_ref.evt) diffs = {diffs, " from_event"};
            if (got.from_ref.note !== want.from_ref.note) diffs = {diffs, " from_note"};
            if (got.to_ref.measure !== want.to_ref.measure) diffs = {diffs, " to_measure"};
            if (got.to_ref.voice_slot !== want.to_ref.voice_slot)
                diffs = {diffs, " to_voice_slot"};
            if (got.to_ref.evt !== want.to_ref.evt) diffs = {diffs, " to_event"};
            if (got.to_ref.note !== want.to_ref.note) diffs = {diffs, " to_note"};
            if (got.voice_tag !== want.voice_tag) diffs = {diffs, " voice_tag"};
            if (diffs != "")
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t: mismatch on%s: exp kind=%0d from=%h to=%h tag=%0d",
                             $realtime, diffs, want.kind, want.from_ref, want.to_ref,
                             want.voice_tag);
                    $display("%0t:   got kind=%0d from=%h to=%h tag=%0d",
                             $realtime, got.kind, got.from_ref, got.to_ref,
                             got.voice_tag);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [3:0]  voice_number;
    logic [6:0]  pitch;
    logic        tie_start;
    logic        tie_stop;
    logic [15:0] measure_index;
    logic [3:0]  voice_slot;
    logic [7:0]  event_index;
    logic [3:0]  note_index;
    logic        result_valid;
    logic [1:0]  kind;
    logic [15:0] from_measure;
    logic [3:0]  from_voice_slot;
    logic [7:0]  from_event;
    logic [3:0]  from_note;
    logic [15:0] to_measure;
    logic [3:0]  to_voice_slot;
    logic [7:0]  to_event;
    logic [3:0]  to_note;
    logic [3:0]  voice_tag;

    tie_tracker  tracker;
    tie_report_t seen_report;
    int          idle_pct;

    keyed_start_stop_pair_matcher_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .voice_number    (voice_number),
        .pitch           (pitch),
        .tie_start       (tie_start),
        .tie_stop        (tie_stop),
        .measure_index   (measure_index),
        .voice_slot      (voice_slot),
        .event_index     (event_index),
        .note_index      (note_index),
        .result_valid    (result_valid),
        .kind            (kind),
        .from_measure    (from_measure),
        .from_voice_slot (from_voice_slot),
        .from_event      (from_event),
        .from_note       (from_note),
        .to_measure      (to_measure),
        .to_voice_slot   (to_voice_slot),
        .to_event        (to_event),
        .to_note         (to_note),
        .voice_tag       (voice_tag)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Reports cannot be held off: take each one at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            seen_report.kind                = kind;
            seen_report.from_ref.measure    = from_measure;
            seen_report.from_ref.voice_slot = from_voice_slot;
            seen_report.from_ref.evt        = from_event;
            seen_report.from_ref.note       = from_note;
            seen_report.to_ref.measure      = to_measure;
            seen_report.to_ref.voice_slot   = to_voice_slot;
            seen_report.to_ref.evt          = to_event;
            seen_report.to_ref.note         = to_note;
            seen_report.voice_tag           = voice_tag;
            tracker.check_report(seen_report);
        end
    end

    function automatic tie_request_t make_request(logic rt, int v, int p, logic ts, logic tp,
                                                  int m, int vs, int ev, int nt);
        tie_request_t r;
        r.req_type  = rt;
        r.voice     = 4'(v);
        r.pitch     = 7'(p);
        r.tie_start = ts;
        r.tie_stop  = tp;
        r.measure   = 16'(m);
        r.vslot     = 4'(vs);
        r.evt       = 8'(ev);
        r.note      = 4'(nt);
        return r;
    endfunction

    function automatic tie_request_t random_request(int slot);
        return make_request(kssp_pkg::REQ_NOTE, slot / kssp_pkg::NUM_PITCHES,
                            slot % kssp_pkg::NUM_PITCHES,
                            1'($urandom), 1'($urandom), int'($urandom_range(65535)),
                            int'($urandom_range(15)), int'($urandom_range(255)),
                            int'($urandom_range(15)));
    endfunction

    task automatic send_request(tie_request_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        req_type      <= r.req_type;
        voice_number  <= r.voice;
        pitch         <= r.pitch;
        tie_start     <= r.tie_start;
        tie_stop      <= r.tie_stop;
        measure_index <= r.measure;
        voice_slot    <= r.vslot;
        event_index   <= r.evt;
        note_index    <= r.note;
        start         <= 1'b1;
        // hold until the block takes the transfer
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_request(r);
    endtask

    task automatic drain_reports();
        start <= 1'b0;
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int count);
        int           pool [$];
        int           slot;
        int           roll;
        tie_request_t r;
        repeat (6) pool.push_back(int'($urandom_range(kssp_pkg::TABLE_DEPTH - 1)));
        pool.sort();
        repeat (count)
        begin
            roll = int'($urandom_range(99));
            if (roll < 85)
                slot = pool[$urandom_range(pool.size() - 1)];
            else
                slot = int'($urandom_range(kssp_pkg::TABLE_DEPTH - 1));
            r = random_request(slot);
            roll = int'($urandom_range(99));
            if (roll < 40)
                {r.tie_start, r.tie_stop} = 2'b10;
            else if (roll < 70)
                {r.tie_start, r.tie_stop} = 2'b01;
            else if (roll < 85)
                {r.tie_start, r.tie_stop} = 2'b11;
            else if (roll < 90)
                {r.tie_start, r.tie_stop} = 2'b00;
            else
                r.req_type = kssp_pkg::REQ_FLUSH;
            send_request(r);
        end
        // end of part: flush the pool in ascending voice-then-pitch order
        foreach (pool[i])
        begin
            r = random_request(pool[i]);
            r.req_type = kssp_pkg::REQ_FLUSH;
            send_request(r);
        end
    endtask

    initial
    begin
        int wait_cycles;
        tracker       = new();
        idle_pct      = 37;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        req_type      <= kssp_pkg::REQ_NOTE;
        voice_number  <= '0;
        pitch         <= '0;
        tie_start     <= 1'b0;
        tie_stop      <= 1'b0;
        measure_index <= '0;
        voice_slot    <= '0;
        event_index   <= '0;
        note_index    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // stop with nothing pending, at the top key and full field values
        send_request(make_request(kssp_pkg::REQ_NOTE, 15, 127, 1'b0, 1'b1, 65535, 15, 255, 15));
        // plain link at the bottom key, all-zero start against all-ones stop
        send_request(make_request(kssp_pkg::REQ_NOTE, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0));
        send_request(make_request(kssp_pkg::REQ_NOTE, 0, 0, 1'b0, 1'b1, 65535, 15, 255, 15));
        send_request(make_request(kssp_pkg::REQ_NOTE, 0, 0, 1'b0, 1'b0, 1234, 5, 67, 8));
        send_request(make_request(kssp_pkg::REQ_NOTE, 0, 0, 1'b0, 1'b1, 1, 1, 1, 1));
        // a second start replaces the first without a report
        send_request(make_request(kssp_pkg::REQ_NOTE, 15, 127, 1'b1, 1'b0, 65535, 15, 255, 15));
        send_request(make_request(kssp_pkg::REQ_NOTE, 15, 127, 1'b1, 1'b0, 43690, 10, 170, 5));
        send_request(make_request(kssp_pkg::REQ_NOTE, 15, 127, 1'b0, 1'b1, 21845, 5, 85, 10));
        // both flags: dangling stop then store, then link then store
        send_request(make_request(kssp_pkg::REQ_NOTE, 3, 64, 1'b1, 1'b1, 100, 2, 30, 4));
        send_request(make_request(kssp_pkg::REQ_NOTE, 3, 64, 1'b1, 1'b1, 101, 3, 31, 5));
        send_request(make_request(kssp_pkg::REQ_NOTE, 3, 64, 1'b1, 1'b1, 102, 4, 32, 6));
        // flush with flags and position set: those are ignored
        send_request(make_request(kssp_pkg::REQ_FLUSH, 3, 64, 1'b1, 1'b1, 65535, 15, 255, 15));
        send_request(make_request(kssp_pkg::REQ_FLUSH, 3, 64, 1'b0, 1'b0, 0, 0, 0, 0));
        // neither flag leaves a pending start alone
        send_request(make_request(kssp_pkg::REQ_NOTE, 5, 5, 1'b1, 1'b0, 777, 9, 200, 3));
        send_request(make_request(kssp_pkg::REQ_NOTE, 5, 5, 1'b0, 1'b0, 888, 1, 100, 2));
        send_request(make_request(kssp_pkg::REQ_FLUSH, 5, 5, 1'b0, 1'b1, 0, 0, 0, 0));
        send_request(make_request(kssp_pkg::REQ_FLUSH, 15, 127, 1'b0, 1'b0, 0, 0, 0, 0));
        // adjacent keys must not alias
        send_request(make_request(kssp_pkg::REQ_NOTE, 8, 1, 1'b1, 1'b0, 11, 1, 11, 1));
        send_request(make_request(kssp_pkg::REQ_NOTE, 8, 0, 1'b0, 1'b1, 22, 2, 22, 2));
        send_request(make_request(kssp_pkg::REQ_NOTE, 7, 1, 1'b0, 1'b1, 33, 3, 33, 3));
        send_request(make_request(kssp_pkg::REQ_NOTE, 8, 1, 1'b0, 1'b1, 44, 4, 44, 4));
        drain_reports();

        run_phase(135);
        drain_reports();
        idle_pct = 48;
        run_phase(135);
        drain_reports();
        idle_pct = 0;
        run_phase(135);
        start <= 1'b0;

        wait_cycles = 0;
        while (tracker.outstanding() > 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (tracker.outstanding() > 0)
        begin
            $display("%0t: %0d expected reports never arrived", $realtime,
                     tracker.outstanding());
            tracker.failures += tracker.outstanding();
        end

        if (tracker.failures == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
